@@ sv/act_pkg.sv @@
// Shared types and constants of the address claim table.
package act_pkg;

   // Fixed addresses of the claimable pool.
   localparam logic [7:0] POOL_BASE        = 8'd128;
   localparam logic [7:0] FALLBACK_ADDRESS = 8'd247;

   // Result codes.
   localparam logic [2:0] OUT_ADDED       = 3'd0;
   localparam logic [2:0] OUT_UPDATED     = 3'd1;
   localparam logic [2:0] OUT_FULL        = 3'd2;
   localparam logic [2:0] OUT_CLAIM       = 3'd3;
   localparam logic [2:0] OUT_READDRESSED = 3'd4;
   localparam logic [2:0] OUT_DELETED     = 3'd5;
   localparam logic [2:0] OUT_NOT_FOUND   = 3'd6;

   // Request modes.
   localparam logic MODE_CLAIM  = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_NAME      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  src_address;
      logic [63:0] peer_name;
   } req_type;

   typedef struct packed {
      logic [2:0] outcome;
      logic [7:0] own_address;
      logic [3:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic [63:0] name;
      logic [7:0]  address;
   } peer_entry_type;

   // Commands to the pool unit: start a free-address scan, or release an address.
   typedef struct packed {
      logic       scan;
      logic       release_en;
      logic [7:0] address;
   } pool_cmd_type;

   // Pool unit status: done pulses with the address taken (or the fallback).
   typedef struct packed {
      logic       done;
      logic [7:0] address;
   } pool_sts_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_POOL   = 4'b1000
   } state_type;

endpackage

@@ sv/act_peer_mem.sv @@
// Peer table storage: name and address per slot, one write and one registered read port.
module act_peer_mem #(
   parameter int unsigned DEPTH = 16,
   localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_idx,
   input  act_pkg::peer_entry_type wr_entry,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_idx,
   output act_pkg::peer_entry_type rd_entry
);

   act_pkg::peer_entry_type mem [DEPTH];
   act_pkg::peer_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_idx];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ sv/act_pool.sv @@
// Address pool bitmap with a one-entry-per-cycle free search and a release port.
module act_pool #(
   parameter int unsigned POOL_SIZE = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  act_pkg::pool_cmd_type pool_cmd,
   output act_pkg::pool_sts_type pool_sts
);

   localparam int unsigned PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

   logic [POOL_SIZE-1:0] taken_ff, taken_in;
   logic                 scan_ff, scan_in;
   logic [PW-1:0]        ptr_ff, ptr_in;
   logic                 done_ff, done_in;
   logic [7:0]           addr_ff, addr_in;
   logic [6:0]           rel_off;
   logic                 rel_hit;

   always_comb begin
      taken_in = taken_ff;
      scan_in  = scan_ff;
      ptr_in   = ptr_ff;
      done_in  = 1'b0;
      addr_in  = addr_ff;

      // Release only addresses inside the pool range.
      rel_off = pool_cmd.address[6:0];
      rel_hit = pool_cmd.address[7] && ({1'b0, rel_off} < 8'(POOL_SIZE));
      if (pool_cmd.release_en && rel_hit) begin
         taken_in[rel_off[PW-1:0]] = 1'b0;
      end

      if (pool_cmd.scan) begin
         scan_in = 1'b1;
         ptr_in  = '0;
      end else if (scan_ff) begin
         priority if (!taken_ff[ptr_ff]) begin
            taken_in[ptr_ff] = 1'b1;
            done_in          = 1'b1;
            addr_in          = act_pkg::POOL_BASE + 8'(ptr_ff);
            scan_in          = 1'b0;
         end else if (ptr_ff == PW'(POOL_SIZE - 1)) begin
            done_in = 1'b1;
            addr_in = act_pkg::FALLBACK_ADDRESS;
            scan_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff <= '0;
         scan_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         taken_ff <= taken_in;
         scan_ff  <= scan_in;
         done_ff  <= done_in;
      end
      ptr_ff  <= ptr_in;
      addr_ff <= addr_in;
   end

   assign pool_sts.done    = done_ff;
   assign pool_sts.address = addr_ff;

endmodule

@@ sv/address_claim_table.sv @@
// Top level of the address claim table: sequencer, peer table and address pool.
//
// One item (a received address claim or a delete by name) is taken when start
// is high and busy is low; busy then stays high until the single result
// appears on rsp_data for one cycle with rsp_valid. The receiver cannot stall:
// the result must be captured in that cycle. A name search walks the peer table
// one slot per cycle through one shared 64-bit name comparator: a read of every
// slot, a last compare and a decide step. Busy drops in the same cycle as the
// result strobe rises, so a new item can be taken from the cycle in which the
// result appears. When our own address is claimed by a peer with a name not
// larger than ours, the pool unit then searches the POOL_SIZE addresses one per
// cycle for a free one before the result is given.
// Configuration writes on the csr_ channel are always ready and are meant to
// come while the block is idle; writing start_address also loads the own
// address. The table and pool come out of reset empty with no clearing pass.
module address_claim_table #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned POOL_SIZE     = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                start,
   output logic                                busy,
   input  act_pkg::req_type                    req_data,
   // Result channel
   output logic                                rsp_valid,
   output act_pkg::rsp_type                    rsp_data,
   // Configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [act_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [63:0]                         csr_data
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

   act_pkg::state_type state_ff, state_in;

   // Item and configuration state
   act_pkg::req_type   req_ff, req_in;
   logic [63:0]        own_name_ff, own_name_in;
   logic [7:0]         cur_addr_ff, cur_addr_in;
   logic [TABLE_ENTRIES-1:0] used_ff, used_in;

   // Scan bookkeeping
   logic [CNT_W-1:0]   ctr_ff, ctr_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [7:0]         hit_addr_ff, hit_addr_in;
   logic               free_ff, free_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [3:0]         slot_ff, slot_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   act_pkg::rsp_type   rsp_ff, rsp_in;

   // Table memory and pool unit hookup
   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_idx;
   act_pkg::peer_entry_type mem_wr_entry;
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_idx;
   act_pkg::peer_entry_type mem_rd_entry;
   act_pkg::pool_cmd_type   pool_cmd;
   act_pkg::pool_sts_type   pool_sts;

   logic [IDX_W-1:0]   scan_idx;
   logic [3:0]         hit_slot;

   act_peer_mem #(
      .DEPTH(TABLE_ENTRIES)
   ) u_mem (
      .clock    (clock),
      .wr_en    (mem_wr_en),
      .wr_idx   (mem_wr_idx),
      .wr_entry (mem_wr_entry),
      .rd_en    (mem_rd_en),
      .rd_idx   (mem_rd_idx),
      .rd_entry (mem_rd_entry)
   );

   act_pool #(
      .POOL_SIZE(POOL_SIZE)
   ) u_pool (
      .clock    (clock),
      .reset    (reset),
      .pool_cmd (pool_cmd),
      .pool_sts (pool_sts)
   );

   assign scan_idx = ctr_ff[IDX_W-1:0];
   assign hit_slot = hit_ff ? 4'(hit_idx_ff) : 4'd0;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      own_name_in  = own_name_ff;
      cur_addr_in  = cur_addr_ff;
      used_in      = used_ff;
      ctr_in       = ctr_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_addr_in  = hit_addr_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      slot_in      = slot_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;

      mem_wr_en            = 1'b0;
      mem_wr_idx           = hit_idx_ff;
      mem_wr_entry.name    = req_ff.peer_name;
      mem_wr_entry.address = req_ff.src_address;
      mem_rd_en            = 1'b0;
      mem_rd_idx           = scan_idx;
      pool_cmd             = '0;
      pool_cmd.address     = hit_addr_ff;

      // Register writes; start_address reloads the own address.
      if (csr_valid) begin
         unique case (csr_index)
            act_pkg::CSR_OWN_NAME:      own_name_in = csr_data;
            act_pkg::CSR_START_ADDRESS: cur_addr_in = csr_data[7:0];
            default:                    own_name_in = own_name_ff;
         endcase
      end

      unique case (state_ff)
         act_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               ctr_in   = '0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = act_pkg::ST_SCAN;
            end
         end

         act_pkg::ST_SCAN: begin
            // Issue one slot read per cycle; note the first idle slot on the way.
            if (ctr_ff != SCAN_END) begin
               mem_rd_en  = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_idx;
               ctr_in     = ctr_ff + 1'b1;
               if (!used_ff[scan_idx] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = scan_idx;
               end
            end
            // Compare the slot read last cycle; the lowest match wins.
            if (cmp_vld_ff && used_ff[cmp_idx_ff] && !hit_ff &&
                mem_rd_entry.name == req_ff.peer_name) begin
               hit_in      = 1'b1;
               hit_idx_in  = cmp_idx_ff;
               hit_addr_in = mem_rd_entry.address;
            end
            if (ctr_ff == SCAN_END && cmp_vld_ff) begin
               state_in = act_pkg::ST_DECIDE;
            end
         end

         act_pkg::ST_DECIDE: begin
            rsp_in.own_address = cur_addr_ff;
            rsp_in.slot_index  = hit_slot;
            if (req_ff.mode == act_pkg::MODE_CLAIM) begin
               // A known peer always gets its new address.
               if (hit_ff) begin
                  mem_wr_en = 1'b1;
               end
               priority if (req_ff.src_address == cur_addr_ff) begin
                  if (req_ff.peer_name > own_name_ff) begin
                     rsp_in.outcome = act_pkg::OUT_CLAIM;
                     rsp_valid_in   = 1'b1;
                     state_in       = act_pkg::ST_IDLE;
                  end else begin
                     // Lost arbitration: move to a pool address.
                     pool_cmd.scan = 1'b1;
                     slot_in       = hit_slot;
                     state_in      = act_pkg::ST_POOL;
                  end
               end else if (hit_ff) begin
                  rsp_in.outcome = act_pkg::OUT_UPDATED;
                  rsp_valid_in   = 1'b1;
                  state_in       = act_pkg::ST_IDLE;
               end else if (free_ff) begin
                  mem_wr_en              = 1'b1;
                  mem_wr_idx             = free_idx_ff;
                  used_in[free_idx_ff]   = 1'b1;
                  rsp_in.outcome         = act_pkg::OUT_ADDED;
                  rsp_in.slot_index      = 4'(free_idx_ff);
                  rsp_valid_in           = 1'b1;
                  state_in               = act_pkg::ST_IDLE;
               end else begin
                  rsp_in.outcome = act_pkg::OUT_FULL;
                  rsp_valid_in   = 1'b1;
                  state_in       = act_pkg::ST_IDLE;
               end
            end else begin
               if (hit_ff) begin
                  // Drop the peer and hand its address back to the pool.
                  used_in[hit_idx_ff] = 1'b0;
                  pool_cmd.release_en = 1'b1;
                  rsp_in.outcome      = act_pkg::OUT_DELETED;
               end else begin
                  rsp_in.outcome      = act_pkg::OUT_NOT_FOUND;
               end
               rsp_valid_in = 1'b1;
               state_in     = act_pkg::ST_IDLE;
            end
         end

         act_pkg::ST_POOL: begin
            // Hold until the pool unit reports the address taken or the fallback.
            if (pool_sts.done) begin
               cur_addr_in        = pool_sts.address;
               rsp_in.outcome     = act_pkg::OUT_READDRESSED;
               rsp_in.own_address = pool_sts.address;
               rsp_in.slot_index  = slot_ff;
               rsp_valid_in       = 1'b1;
               state_in           = act_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = act_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= act_pkg::ST_IDLE;
         own_name_ff  <= '0;
         cur_addr_ff  <= act_pkg::POOL_BASE;
         used_ff      <= '0;
         ctr_ff       <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         own_name_ff  <= own_name_in;
         cur_addr_ff  <= cur_addr_in;
         used_ff      <= used_in;
         ctr_ff       <= ctr_in;
         cmp_vld_ff   <= cmp_vld_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_addr_ff <= hit_addr_in;
      free_idx_ff <= free_idx_in;
      slot_ff     <= slot_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != act_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ sv/act_checker.sv @@
// Port-level checks of the address claim table, bound to the top level.
module act_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input act_pkg::rsp_type rsp_data
);

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted item");

   // The result strobe marks the end of an item, exactly when busy drops.
   a_result_ends_item: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // Each item passes through a scan and a decide state, so strobes never come back to back.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // Outcomes that touch no slot report slot zero.
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.outcome == act_pkg::OUT_FULL ||
                    rsp_data.outcome == act_pkg::OUT_NOT_FOUND)
      |-> rsp_data.slot_index == 4'd0)
      else $error("slot reported for an outcome without a slot");

   // A new own address comes from the pool range or the fallback.
   a_readdress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.outcome == act_pkg::OUT_READDRESSED
      |-> rsp_data.own_address[7] ||
          rsp_data.own_address == act_pkg::FALLBACK_ADDRESS)
      else $error("readdressed outside the pool");

endmodule

bind address_claim_table act_checker u_act_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
